>>> rtl/ansi_escape_visible_length_assert.svh
// Assertion macros for the ANSI escape visible-length block.
// Used by the checker module; no other dependencies.
`ifndef ANSI_ESCAPE_VISIBLE_LENGTH_ASSERT_SVH
`define ANSI_ESCAPE_VISIBLE_LENGTH_ASSERT_SVH

// Property checked outside reset.
`define AEVL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aevl assertion failed");

// Property that also holds across reset.
`define AEVL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("aevl reset assertion failed");

`endif

>>> rtl/aevl_pkg.sv
// Shared types and constants for the ANSI escape visible-length block.
// No dependencies.
package aevl_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int VIS_BITS        = 16;
  localparam int STATUS_BITS     = 2;
  localparam int KIND_BITS       = 4;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LOW_M  = 8'h6D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_UP_J   = 8'h4A;
  localparam logic [7:0] CH_UP_K   = 8'h4B;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D2     = 8'h32;
  localparam logic [7:0] CH_D3     = 8'h33;
  localparam logic [7:0] CH_D5     = 8'h35;
  localparam logic [7:0] CH_D6     = 8'h36;
  localparam logic [7:0] CH_D9     = 8'h39;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_PEND = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef enum logic [KIND_BITS-1:0] {
    K_NONE    = 4'd0,
    K_PLAIN   = 4'd1,
    K_UP      = 4'd2,
    K_DOWN    = 4'd3,
    K_RIGHT   = 4'd4,
    K_LEFT    = 4'd5,
    K_CLRSCR  = 4'd6,
    K_CLRLINE = 4'd7,
    K_SHOW    = 4'd8,
    K_HIDE    = 4'd9,
    K_DEL     = 4'd10,
    K_SGR     = 4'd11,
    K_CURREQ  = 4'd12,
    K_CURRES  = 4'd13,
    K_CURSET  = 4'd14,
    K_ABORT   = 4'd15
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ESC      = 4'd1,
    PH_LBRACKET = 4'd2,
    PH_QMARK    = 4'd3,
    PH_PRIV2    = 4'd4,
    PH_PRIV25   = 4'd5,
    PH_ARG0     = 4'd6,
    PH_ARG0_3   = 4'd7,
    PH_ARG0_6   = 4'd8,
    PH_SEMI0    = 4'd9,
    PH_ARG1     = 4'd10,
    PH_SEMIN    = 4'd11,
    PH_ARGN     = 4'd12
  } phase_t;

  // Character classes resolved by the front end.
  typedef enum logic [4:0] {
    CC_OTHER,
    CC_ESC,
    CC_LBRACK,
    CC_QMARK,
    CC_MOVE,
    CC_DIGIT,
    CC_DIG2,
    CC_DIG3,
    CC_DIG5,
    CC_DIG6,
    CC_SEMI,
    CC_LOW_M,
    CC_LOW_N,
    CC_TILDE,
    CC_UP_R,
    CC_UP_H,
    CC_LOW_H,
    CC_LOW_L
  } cls_t;

  typedef struct packed {
    cls_t  cls;
    kind_t mkind;  // cursor/clear kind when cls is CC_MOVE
    logic  last;
  } word_t;

endpackage

>>> rtl/aevl_front.sv
// Front end: takes input words and classifies each character.
// Depends on aevl_pkg.
module aevl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [7:0]    byte_req,
  input  logic          last,
  output logic          fv,
  output aevl_pkg::word_t fword,
  input  logic          q_ready
);
  import aevl_pkg::*;

  word_t cword;
  logic  load;
  logic  push;

  assign push      = fv && q_ready;
  assign req_stall = fv && !q_ready;
  assign load      = req_valid && !req_stall;

  always_comb begin
    cword.mkind = K_NONE;
    cword.last  = last;
    cword.cls   = CC_OTHER;
    unique case (byte_req)
      CH_ESC:    cword.cls = CC_ESC;
      CH_LBRACK: cword.cls = CC_LBRACK;
      CH_QMARK:  cword.cls = CC_QMARK;
      CH_TILDE:  cword.cls = CC_TILDE;
      CH_SEMI:   cword.cls = CC_SEMI;
      CH_LOW_M:  cword.cls = CC_LOW_M;
      CH_LOW_N:  cword.cls = CC_LOW_N;
      CH_UP_R:   cword.cls = CC_UP_R;
      CH_UP_H:   cword.cls = CC_UP_H;
      CH_LOW_H:  cword.cls = CC_LOW_H;
      CH_LOW_L:  cword.cls = CC_LOW_L;
      CH_D2:     cword.cls = CC_DIG2;
      CH_D3:     cword.cls = CC_DIG3;
      CH_D5:     cword.cls = CC_DIG5;
      CH_D6:     cword.cls = CC_DIG6;
      CH_UP_A: begin cword.cls = CC_MOVE; cword.mkind = K_UP;      end
      CH_UP_B: begin cword.cls = CC_MOVE; cword.mkind = K_DOWN;    end
      CH_UP_C: begin cword.cls = CC_MOVE; cword.mkind = K_RIGHT;   end
      CH_UP_D: begin cword.cls = CC_MOVE; cword.mkind = K_LEFT;    end
      CH_UP_J: begin cword.cls = CC_MOVE; cword.mkind = K_CLRSCR;  end
      CH_UP_K: begin cword.cls = CC_MOVE; cword.mkind = K_CLRLINE; end
      default: begin
        if (byte_req >= CH_D0 && byte_req <= CH_D9) cword.cls = CC_DIGIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) fword <= cword;
  end

endmodule

>>> rtl/aevl_queue.sv
// Short FIFO of classified words between front and back end.
// Depends on aevl_pkg.
module aevl_queue #(
  parameter int DEPTH = aevl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  aevl_pkg::word_t wdata,
  output logic            ready,
  output logic            q_valid,
  output aevl_pkg::word_t rdata,
  input  logic            pop
);
  import aevl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign ready   = cnt != CNT_W'(DEPTH);
  assign q_valid = cnt != '0;
  assign rdata   = mem[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

>>> rtl/aevl_back.sv
// Back end: escape-sequence phase machine, visible count and result register.
// Depends on aevl_pkg.
module aevl_back #(
  parameter int COUNT_BITS = aevl_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  aevl_pkg::word_t                 qword,
  output logic                            pop,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [aevl_pkg::STATUS_BITS-1:0] status,
  output logic [aevl_pkg::KIND_BITS-1:0]   kind,
  output logic [aevl_pkg::VIS_BITS-1:0]    visible_count,
  output logic                            end_of_string
);
  import aevl_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_upd;
  status_t               st;
  kind_t                 knd;
  logic                  is_dig;
  cls_t                  c;

  assign c      = qword.cls;
  assign is_dig = c inside {CC_DIGIT, CC_DIG2, CC_DIG3, CC_DIG5, CC_DIG6};
  assign pop    = q_valid && (!res_valid || !res_stall);

  always_comb begin
    st         = ST_FAIL;
    knd        = K_NONE;
    phase_next = phase;
    unique case (phase) inside
      PH_IDLE: begin
        if (c == CC_ESC) begin
          st = ST_PEND; phase_next = PH_ESC;
        end else begin
          st = ST_DONE; knd = K_PLAIN;
        end
      end
      PH_ESC: begin
        if (c == CC_LBRACK) begin
          st = ST_PEND; phase_next = PH_LBRACKET;
        end else begin
          st = ST_DONE; knd = K_ABORT;
        end
      end
      PH_LBRACKET: begin
        if (c == CC_QMARK) begin
          st = ST_PEND; phase_next = PH_QMARK;
        end else if (c == CC_MOVE) begin
          st = ST_DONE; knd = qword.mkind;
        end else if (c == CC_DIG3) begin
          st = ST_PEND; phase_next = PH_ARG0_3;
        end else if (c == CC_DIG6) begin
          st = ST_PEND; phase_next = PH_ARG0_6;
        end else if (is_dig) begin
          st = ST_PEND; phase_next = PH_ARG0;
        end
      end
      PH_QMARK: begin
        if (c == CC_DIG2) begin
          st = ST_PEND; phase_next = PH_PRIV2;
        end
      end
      PH_PRIV2: begin
        if (c == CC_DIG5) begin
          st = ST_PEND; phase_next = PH_PRIV25;
        end
      end
      PH_PRIV25: begin
        if (c == CC_LOW_H) begin
          st = ST_DONE; knd = K_SHOW;
        end else if (c == CC_LOW_L) begin
          st = ST_DONE; knd = K_HIDE;
        end
      end
      PH_ARG0, PH_ARG0_3, PH_ARG0_6: begin
        if (is_dig) begin
          st = ST_PEND; phase_next = PH_ARG0;
        end else if (c == CC_SEMI) begin
          st = ST_PEND; phase_next = PH_SEMI0;
        end else if (c == CC_MOVE) begin
          st = ST_DONE; knd = qword.mkind;
        end else if (c == CC_LOW_M && phase != PH_ARG0_6) begin
          st = ST_DONE; knd = K_SGR;
        end else if (c == CC_TILDE && phase == PH_ARG0_3) begin
          st = ST_DONE; knd = K_DEL;
        end else if (c == CC_LOW_N && phase == PH_ARG0_6) begin
          st = ST_DONE; knd = K_CURREQ;
        end
      end
      PH_SEMI0: begin
        if (is_dig) begin
          st = ST_PEND; phase_next = PH_ARG1;
        end
      end
      PH_ARG1: begin
        if (is_dig) begin
          st = ST_PEND;
        end else if (c == CC_LOW_M) begin
          st = ST_DONE; knd = K_SGR;
        end else if (c == CC_UP_R) begin
          st = ST_DONE; knd = K_CURRES;
        end else if (c == CC_UP_H) begin
          st = ST_DONE; knd = K_CURSET;
        end else if (c == CC_SEMI) begin
          st = ST_PEND; phase_next = PH_SEMIN;
        end
      end
      PH_SEMIN: begin
        if (is_dig) begin
          st = ST_PEND; phase_next = PH_ARGN;
        end
      end
      PH_ARGN: begin
        if (is_dig) begin
          st = ST_PEND;
        end else if (c == CC_LOW_M) begin
          st = ST_DONE; knd = K_SGR;
        end else if (c == CC_SEMI) begin
          st = ST_PEND; phase_next = PH_SEMIN;
        end
      end
      default: begin
        st = ST_FAIL;
      end
    endcase
    if (st == ST_DONE) phase_next = PH_IDLE;
  end

  // saturating count of visible characters
  assign count_upd = (knd == K_PLAIN && count != '1) ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        res_valid <= 1'b1;
        if (qword.last) begin
          phase <= PH_IDLE;
          count <= '0;
        end else begin
          phase <= phase_next;
          count <= count_upd;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status        <= st;
      kind          <= knd;
      visible_count <= VIS_BITS'(count_upd);
      end_of_string <= qword.last;
    end
  end

endmodule

>>> rtl/ansi_escape_visible_length.sv
// An accepted input word passes through the front register, then the queue, then
// the result register. Throughput: one word per cycle while res_stall is low; the
// back end updates the phase and count for each popped word.
// Reset (rst, synchronous, active high) clears the phase, the visible count,
// the queue and all valid flags; no clearing pass is needed.
module ansi_escape_visible_length #(
  parameter int COUNT_BITS  = aevl_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = aevl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [7:0]                       byte_req,
  input  logic                             last,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [aevl_pkg::STATUS_BITS-1:0] status,
  output logic [aevl_pkg::KIND_BITS-1:0]   kind,
  output logic [aevl_pkg::VIS_BITS-1:0]    visible_count,
  output logic                             end_of_string
);
  import aevl_pkg::*;

  logic  fv;
  word_t fword;
  logic  q_ready;
  logic  q_valid;
  word_t qword;
  logic  pop;

  aevl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .byte_req  (byte_req),
    .last      (last),
    .fv        (fv),
    .fword     (fword),
    .q_ready   (q_ready)
  );

  aevl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fv),
    .wdata   (fword),
    .ready   (q_ready),
    .q_valid (q_valid),
    .rdata   (qword),
    .pop     (pop)
  );

  aevl_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .qword         (qword),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .kind          (kind),
    .visible_count (visible_count),
    .end_of_string (end_of_string)
  );

endmodule

>>> rtl/aevl_checker.sv
// Port-level checks for the ANSI escape visible-length block, bound to the top.
// Depends on aevl_pkg and ansi_escape_visible_length_assert.svh.
`include "ansi_escape_visible_length_assert.svh"

module aevl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_stall,
  input logic [aevl_pkg::STATUS_BITS-1:0] status,
  input logic [aevl_pkg::KIND_BITS-1:0]   kind,
  input logic [aevl_pkg::VIS_BITS-1:0]    visible_count,
  input logic                             end_of_string
);
  import aevl_pkg::*;

  logic [STATUS_BITS+KIND_BITS+VIS_BITS:0] res_word;

  assign res_word = {status, kind, visible_count, end_of_string};

  // a held word keeps its payload
  `AEVL_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res_word))

  // pending and failed words carry no kind
  `AEVL_ASSERT(a_kind_none, clk, rst, res_valid && status != ST_DONE |-> kind == K_NONE)

  // completed words always name what completed
  `AEVL_ASSERT(a_kind_done, clk, rst, res_valid && status == ST_DONE |-> kind != K_NONE)

  // reset empties the result register
  `AEVL_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !res_valid)

endmodule

bind ansi_escape_visible_length aevl_checker u_aevl_checker (.*);
